// ===== hw/rtl/lcdfmt_pkg.sv =====
// Shared constants, opcodes and the digit-to-ASCII helper for the display text formatter.
// Used by lcdfmt_bcd and lcd_number_text_formatter. No dependencies.
package lcdfmt_pkg;

  localparam int MAX_DIGITS_DEF = 16;
  localparam int NUM_W          = 16;  // width of the number field
  localparam int BCD_W          = 20;  // five decimal digits cover 0..65535
  localparam int BCD_DIGITS     = BCD_W / 4;

  typedef enum logic [2:0] {
    OP_UDEC = 3'd0,
    OP_SDEC = 3'd1,
    OP_HEX  = 3'd2,
    OP_BIN  = 3'd3,
    OP_CHAR = 3'd4
  } opcode_t;

  localparam logic [7:0] CURSOR_CMD  = 8'h80;
  localparam logic [7:0] ROW2_OFFSET = 8'h40;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_A     = 8'h41;
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  function automatic logic [7:0] digit_ascii(input logic [3:0] d);
    logic [7:0] d8;
    d8 = {4'b0000, d};
    if (d < 4'd10) begin
      return ASCII_ZERO + d8;
    end
    return ASCII_A + d8 - 8'd10;
  endfunction

endpackage

// ===== hw/rtl/lcdfmt_bcd.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on lcdfmt_pkg for the field widths.
module lcdfmt_bcd (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic [lcdfmt_pkg::NUM_W-1:0] value,
  output logic [lcdfmt_pkg::BCD_W-1:0] bcd,
  output logic                         done
);

  localparam int CNT_W = $clog2(lcdfmt_pkg::NUM_W + 1);

  logic [lcdfmt_pkg::NUM_W-1:0] bin_r;
  logic [lcdfmt_pkg::BCD_W-1:0] bcd_r;
  logic [lcdfmt_pkg::BCD_W-1:0] adj;
  logic [CNT_W-1:0]             cnt_r;
  logic                         run_r;
  logic                         done_r;

  // add 3 to every digit of 5 or more before the next shift
  always_comb begin
    for (int i = 0; i < lcdfmt_pkg::BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (load) begin
      bin_r  <= value;
      bcd_r  <= '0;
      cnt_r  <= CNT_W'(lcdfmt_pkg::NUM_W);
      run_r  <= 1'b1;
      done_r <= 1'b0;
    end else if (run_r) begin
      bcd_r <= {adj[lcdfmt_pkg::BCD_W-2:0], bin_r[lcdfmt_pkg::NUM_W-1]};
      bin_r <= {bin_r[lcdfmt_pkg::NUM_W-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign bcd  = bcd_r;
  assign done = done_r;

endmodule

// ===== hw/rtl/lcd_number_text_formatter.sv =====
// Top level of the character display text formatter: cursor command, sign and digits.
// Depends on lcdfmt_pkg and lcdfmt_bcd.
//
//  channel  | ports                                        | transfer when
//  ---------+----------------------------------------------+---------------------------
//  request  | in_opcode in_row in_column in_number         | start high, busy low
//           | in_digit_count in_character                  |
//  result   | out_is_data out_byte out_last                | out_valid high (one cycle)
//
// One byte leaves per cycle once the request is decoded, except that decimal
// digits wait in S_DIGIT until the 16-step shift-and-add-3 converter is done;
// the cursor and sign bytes of a decimal request do not wait on the converter.
// Reset (rst_n low, synchronous) drops any request in flight and clears the strobe.
// The receiver cannot stall; each result is shown for exactly one cycle.
module lcd_number_text_formatter #(
  parameter int MAX_DIGITS = lcdfmt_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_opcode,
  input  logic [1:0]                   in_row,
  input  logic [5:0]                   in_column,
  input  logic [lcdfmt_pkg::NUM_W-1:0] in_number,
  input  logic [4:0]                   in_digit_count,
  input  logic [7:0]                   in_character,
  output logic                         out_valid,
  output logic                         out_is_data,
  output logic [7:0]                   out_byte,
  output logic                         out_last
);

  localparam int CW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CURSOR,
    S_SIGN,
    S_DIGIT,
    S_CHAR
  } state_t;

  state_t                       state_r;
  state_t                       after_cursor;
  state_t                       first_state;

  logic                         accept;
  logic                         op_valid;
  logic                         is_dec;
  logic                         is_neg;
  logic                         sign_on;
  logic [lcdfmt_pkg::NUM_W-1:0] magnitude;
  logic [CW-1:0]                ndig;
  logic [7:0]                   col8;
  logic [7:0]                   cursor_byte;

  // request context held for the whole request
  logic                         dec_r;
  logic                         binary_r;
  logic                         char_mode_r;
  logic                         has_sign_r;
  logic [7:0]                   sign_byte_r;
  logic [7:0]                   cursor_byte_r;
  logic [7:0]                   char_r;
  logic [lcdfmt_pkg::NUM_W-1:0] word_r;
  logic [CW-1:0]                cnt_r;

  // registered result
  logic                         out_valid_r;
  logic                         out_is_data_r;
  logic [7:0]                   out_byte_r;
  logic                         out_last_r;

  logic [lcdfmt_pkg::BCD_W-1:0] bcd_w;
  logic                         bcd_done;
  logic [lcdfmt_pkg::BCD_W-1:0] digit_word;
  logic [lcdfmt_pkg::BCD_W-1:0] shifted;
  logic [CW-1:0]                pos;
  logic [3:0]                   digit;
  logic                         digit_ready;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Decode the incoming request
  // ---------------------------------------------------------------------------
  assign op_valid = (in_opcode <= lcdfmt_pkg::OP_CHAR);
  assign is_dec   = (in_opcode == lcdfmt_pkg::OP_UDEC) || (in_opcode == lcdfmt_pkg::OP_SDEC);
  assign is_neg   = (in_opcode == lcdfmt_pkg::OP_SDEC) && in_number[lcdfmt_pkg::NUM_W-1];
  // zero gets no sign in signed mode
  assign sign_on  = (in_opcode == lcdfmt_pkg::OP_SDEC) && (in_number != '0);
  // most negative value yields 32768, which still fits the field width
  assign magnitude = is_neg ? (~in_number + 1'b1) : in_number;

  // saturate the digit count to MAX_DIGITS
  always_comb begin
    if (in_digit_count > 5'(MAX_DIGITS)) begin
      ndig = CW'(MAX_DIGITS);
    end else begin
      ndig = CW'(in_digit_count);
    end
  end

  // address term wraps modulo 256 before the command bit is OR'd in
  assign col8 = {2'b00, in_column} - 8'd1;
  always_comb begin
    if (in_row == 2'd2) begin
      cursor_byte = lcdfmt_pkg::CURSOR_CMD | (lcdfmt_pkg::ROW2_OFFSET + col8);
    end else begin
      cursor_byte = lcdfmt_pkg::CURSOR_CMD | col8;
    end
  end

  always_comb begin
    priority if (in_row == 2'd1 || in_row == 2'd2) begin
      first_state = S_CURSOR;
    end else if (in_opcode == lcdfmt_pkg::OP_CHAR) begin
      first_state = S_CHAR;
    end else if (sign_on) begin
      first_state = S_SIGN;
    end else if (ndig != '0) begin
      first_state = S_DIGIT;
    end else begin
      first_state = S_IDLE;
    end
  end

  always_comb begin
    priority if (char_mode_r) begin
      after_cursor = S_CHAR;
    end else if (has_sign_r) begin
      after_cursor = S_SIGN;
    end else if (cnt_r != '0) begin
      after_cursor = S_DIGIT;
    end else begin
      after_cursor = S_IDLE;
    end
  end

  // ---------------------------------------------------------------------------
  // Digit pick: decimal reads BCD nibbles, hex reads the number's nibbles,
  // binary reads single bits. Positions above the value shift in zeros.
  // ---------------------------------------------------------------------------
  lcdfmt_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept && op_valid && is_dec),
    .value (magnitude),
    .bcd   (bcd_w),
    .done  (bcd_done)
  );

  assign digit_word  = dec_r ? bcd_w : {4'b0000, word_r};
  assign pos         = cnt_r - 1'b1;
  assign shifted     = binary_r ? (digit_word >> pos) : (digit_word >> {pos, 2'b00});
  assign digit       = binary_r ? {3'b000, shifted[0]} : shifted[3:0];
  assign digit_ready = !dec_r || bcd_done;

  // ---------------------------------------------------------------------------
  // Sequencer: one byte per cycle, hold in S_DIGIT until the BCD is ready
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && op_valid) begin
            dec_r         <= is_dec;
            binary_r      <= (in_opcode == lcdfmt_pkg::OP_BIN);
            char_mode_r   <= (in_opcode == lcdfmt_pkg::OP_CHAR);
            has_sign_r    <= sign_on;
            sign_byte_r   <= is_neg ? lcdfmt_pkg::ASCII_MINUS : lcdfmt_pkg::ASCII_PLUS;
            cursor_byte_r <= cursor_byte;
            char_r        <= in_character;
            word_r        <= in_number;
            cnt_r         <= (in_opcode == lcdfmt_pkg::OP_CHAR) ? '0 : ndig;
            state_r       <= first_state;
          end
        end
        S_CURSOR: begin
          out_valid_r   <= 1'b1;
          out_is_data_r <= 1'b0;
          out_byte_r    <= cursor_byte_r;
          out_last_r    <= (after_cursor == S_IDLE);
          state_r       <= after_cursor;
        end
        S_SIGN: begin
          out_valid_r   <= 1'b1;
          out_is_data_r <= 1'b1;
          out_byte_r    <= sign_byte_r;
          out_last_r    <= (cnt_r == '0);
          state_r       <= (cnt_r == '0) ? S_IDLE : S_DIGIT;
        end
        S_DIGIT: begin
          if (digit_ready) begin
            out_valid_r   <= 1'b1;
            out_is_data_r <= 1'b1;
            out_byte_r    <= lcdfmt_pkg::digit_ascii(digit);
            out_last_r    <= (cnt_r == CW'(1));
            cnt_r         <= cnt_r - 1'b1;
            if (cnt_r == CW'(1)) begin
              state_r   <= S_IDLE;
            end
          end
        end
        S_CHAR: begin
          out_valid_r   <= 1'b1;
          out_is_data_r <= 1'b1;
          out_byte_r    <= char_r;
          out_last_r    <= 1'b1;
          state_r       <= S_IDLE;
        end
        default: begin
          state_r       <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_is_data = out_is_data_r;
  assign out_byte    = out_byte_r;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  // a byte only comes out of a request in progress
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request in progress");

  // the last byte ends the request: the block is free and no byte follows directly
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (!busy ##1 !out_valid))
    else $error("byte after the last byte of a request");

  // digit emission always has digits left to send
  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIGIT) |-> (cnt_r != '0))
    else $error("digit state with no digits left");

  // converter output holds valid decimal digits once done
  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    bcd_done |-> ((bcd_w[3:0] < 4'd10) && (bcd_w[7:4] < 4'd10) && (bcd_w[11:8] < 4'd10)
                  && (bcd_w[15:12] < 4'd10) && (bcd_w[19:16] < 4'd10)))
    else $error("converter produced a digit above nine");
`endif

endmodule
